// File: design/button_press_duration_classifier_unit_assert.svh
// Assertion macros shared by the classifier sources.
// Each one expects clk and arst_n in the scope where it is used.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPDC_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPDC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/bpdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

	localparam int REG_W      = 20;
	localparam int NUM_BTN    = 4;
	localparam int MAX_EVENTS = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef logic [2:0] event_t;
	typedef logic [1:0] button_t;

	localparam event_t EV_POWER_LONG   = 3'd0;
	localparam event_t EV_INIT         = 3'd1;
	localparam event_t EV_WPS_DOWN     = 3'd2;
	localparam event_t EV_WPS_UP       = 3'd3;
	localparam event_t EV_UNMOUNT      = 3'd4;
	localparam event_t EV_RESET_SHORT  = 3'd5;
	localparam event_t EV_IMPORT_SHORT = 3'd6;

	localparam button_t BTN_POWER  = 2'd0;
	localparam button_t BTN_RESET  = 2'd1;
	localparam button_t BTN_WPS    = 2'd2;
	localparam button_t BTN_IMPORT = 2'd3;

	localparam logic OP_SAMPLE   = 1'b0;
	localparam logic OP_TICK     = 1'b1;
	localparam logic LVL_PRESSED = 1'b0;

	localparam logic [1:0] CFG_POWER_HOLD   = 2'd0;
	localparam logic [1:0] CFG_RESET_HOLD   = 2'd1;
	localparam logic [1:0] CFG_IMPORT_HOLD  = 2'd2;
	localparam logic [1:0] CFG_SHORT_WINDOW = 2'd3;

	typedef struct packed {
		logic    op;
		button_t button;
		logic    level;
	} item_t;

	typedef struct packed {
		logic [REG_W-1:0] power_hold;
		logic [REG_W-1:0] reset_hold;
		logic [REG_W-1:0] import_hold;
		logic [REG_W-1:0] short_window;
	} cfg_t;

	// Events caused by one item, packed from slot 0 up.
	typedef struct packed {
		logic [1:0]                  count;
		logic [MAX_EVENTS-1:0][2:0]  code;
	} ev_batch_t;

	typedef struct packed {
		event_t code;
		logic   last;
	} fifo_entry_t;

endpackage

`default_nettype wire

// File: design/bpdc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_duration_classifier_unit_assert.svh"

module bpdc_classify #(
	parameter int COUNTER_WIDTH = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire bpdc_pkg::item_t    item,
	input  wire bpdc_pkg::cfg_t     cfg,
	output bpdc_pkg::ev_batch_t     batch
);

	localparam int CMP_W = (COUNTER_WIDTH > bpdc_pkg::REG_W) ? COUNTER_WIDTH : bpdc_pkg::REG_W;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	logic [bpdc_pkg::NUM_BTN-1:0][COUNTER_WIDTH-1:0] elapsed_q, elapsed_nxt;
	logic [bpdc_pkg::NUM_BTN-1:0]                    armed_q, armed_nxt;

	always_comb begin
		logic [bpdc_pkg::NUM_BTN-1:0][COUNTER_WIDTH-1:0] inc;
		logic [bpdc_pkg::NUM_BTN-1:0]                    long_hit;
		logic [1:0]                                      n;
		logic [CMP_W-1:0]                                hold_x;

		elapsed_nxt = elapsed_q;
		armed_nxt   = armed_q;
		batch       = '0;
		n           = '0;
		long_hit    = '0;
		hold_x      = '0;
		for (int i = 0; i < bpdc_pkg::NUM_BTN; i++) begin
			inc[i] = (elapsed_q[i] == CNT_MAX) ? elapsed_q[i] : elapsed_q[i] + 1'b1;
		end

		if (item.op == bpdc_pkg::OP_TICK) begin
			elapsed_nxt = inc;
			hold_x = CMP_W'(cfg.power_hold);
			long_hit[bpdc_pkg::BTN_POWER] = armed_q[bpdc_pkg::BTN_POWER]
				&& (CMP_W'(inc[bpdc_pkg::BTN_POWER]) >= hold_x);
			hold_x = CMP_W'(cfg.reset_hold);
			long_hit[bpdc_pkg::BTN_RESET] = armed_q[bpdc_pkg::BTN_RESET]
				&& (CMP_W'(inc[bpdc_pkg::BTN_RESET]) >= hold_x);
			hold_x = CMP_W'(cfg.import_hold);
			long_hit[bpdc_pkg::BTN_IMPORT] = armed_q[bpdc_pkg::BTN_IMPORT]
				&& (CMP_W'(inc[bpdc_pkg::BTN_IMPORT]) >= hold_x);

			// Pack long events in fixed order: power, reset, import.
			if (long_hit[bpdc_pkg::BTN_POWER]) begin
				armed_nxt[bpdc_pkg::BTN_POWER] = 1'b0;
				batch.code[n] = bpdc_pkg::EV_POWER_LONG;
				n = n + 2'd1;
			end
			if (long_hit[bpdc_pkg::BTN_RESET]) begin
				armed_nxt[bpdc_pkg::BTN_RESET] = 1'b0;
				batch.code[n] = bpdc_pkg::EV_INIT;
				n = n + 2'd1;
			end
			if (long_hit[bpdc_pkg::BTN_IMPORT]) begin
				armed_nxt[bpdc_pkg::BTN_IMPORT] = 1'b0;
				batch.code[n] = bpdc_pkg::EV_UNMOUNT;
				n = n + 2'd1;
			end
		end else if (item.level == bpdc_pkg::LVL_PRESSED) begin
			elapsed_nxt[item.button] = '0;
			if (item.button == bpdc_pkg::BTN_WPS) begin
				batch.code[0] = bpdc_pkg::EV_WPS_DOWN;
				n = 2'd1;
			end else begin
				armed_nxt[item.button] = 1'b1;
			end
		end else begin
			if (item.button == bpdc_pkg::BTN_WPS) begin
				batch.code[0] = bpdc_pkg::EV_WPS_UP;
				n = 2'd1;
			end else begin
				armed_nxt[item.button] = 1'b0;
				if (item.button != bpdc_pkg::BTN_POWER
					&& CMP_W'(elapsed_q[item.button]) <= CMP_W'(cfg.short_window)) begin
					batch.code[0] = (item.button == bpdc_pkg::BTN_RESET) ?
						bpdc_pkg::EV_RESET_SHORT : bpdc_pkg::EV_IMPORT_SHORT;
					n = 2'd1;
				end
			end
		end
		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			armed_q   <= '0;
		end else if (fire) begin
			elapsed_q <= elapsed_nxt;
			armed_q   <= armed_nxt;
		end
	end

	`BPDC_ASSERT_NEXT(a_reset_press_arms,
		fire && item.op == bpdc_pkg::OP_SAMPLE && item.level == bpdc_pkg::LVL_PRESSED
			&& item.button == bpdc_pkg::BTN_RESET,
		armed_q[bpdc_pkg::BTN_RESET], "reset press did not arm its timer")
	`BPDC_ASSERT_IMP(a_sample_single_event, fire && item.op == bpdc_pkg::OP_SAMPLE,
		batch.count <= 2'd1, "level sample produced more than one event")

endmodule

`default_nettype wire

// File: design/bpdc_event_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_duration_classifier_unit_assert.svh"

module bpdc_event_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire bpdc_pkg::ev_batch_t   batch,
	input  wire logic                  pop,
	output logic [bpdc_pkg::FIFO_AW:0] count,
	output bpdc_pkg::fifo_entry_t      head
);

	localparam int AW = bpdc_pkg::FIFO_AW;

	bpdc_pkg::fifo_entry_t mem_q [bpdc_pkg::FIFO_DEPTH];
	logic [AW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [AW:0]           count_q;
	logic [1:0]            push_n;

	assign push_n = push ? batch.count : 2'd0;
	assign count  = count_q;
	assign head   = mem_q[rd_ptr_q];

	// Write the whole batch at once; flag the final entry as last.
	always_ff @(posedge clk) begin
		for (int k = 0; k < bpdc_pkg::MAX_EVENTS; k++) begin
			if (2'(k) < push_n) begin
				mem_q[wr_ptr_q + AW'(k)] <= '{code: batch.code[k],
					last: (2'(k) == push_n - 2'd1)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW + 1)'(push_n) - (AW + 1)'(pop);
		end
	end

	`BPDC_ASSERT_IMP(a_no_overflow, push_n != 2'd0,
		count_q + (AW + 1)'(push_n) <= (AW + 1)'(bpdc_pkg::FIFO_DEPTH),
		"event queue overflow")
	`BPDC_ASSERT_IMP(a_no_underflow, pop, count_q != '0, "event queue underflow")

endmodule

`default_nettype wire

// File: design/button_press_duration_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Button press classifier for power, reset, wps and import. Each input beat is
// either a level sample for one button (raw_level 0 = pressed) or one time tick
// (operation 1). An accepted beat is held in the stage-1 register until the queue
// has room, then evaluated against the per-button elapsed counters and armed
// flags; its events (none, one, or up to three long-press events on a tick, in
// the order power_long, init, unmount) are pushed into a four-entry event queue,
// and the last event of a beat carries last_event = 1. One beat is accepted per
// cycle as long as the queue holds at most one pending event, so beats that
// cause at most one event each are taken one per cycle while out_ready stays
// high. Hold and short-window registers reset to 3 s, 10 s, 3 s and 2 s worth of
// ticks and are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// No clearing pass is needed after reset.
module button_press_duration_classifier_unit #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int COUNTER_WIDTH    = 20
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       operation,
	input  wire logic [1:0]                 button,
	input  wire logic                       raw_level,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [2:0]                      event_code,
	output logic                            last_event,
	// configuration write port
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [bpdc_pkg::REG_W-1:0] cfg_data
);

	localparam logic [bpdc_pkg::REG_W-1:0] POWER_HOLD_RST   =
		bpdc_pkg::REG_W'(3 * TICKS_PER_SECOND);
	localparam logic [bpdc_pkg::REG_W-1:0] RESET_HOLD_RST   =
		bpdc_pkg::REG_W'(10 * TICKS_PER_SECOND);
	localparam logic [bpdc_pkg::REG_W-1:0] IMPORT_HOLD_RST  =
		bpdc_pkg::REG_W'(3 * TICKS_PER_SECOND);
	localparam logic [bpdc_pkg::REG_W-1:0] SHORT_WINDOW_RST =
		bpdc_pkg::REG_W'(2 * TICKS_PER_SECOND);

	// Queue must keep room for a full three-event batch before a beat evaluates.
	localparam logic [bpdc_pkg::FIFO_AW:0] ROOM_LIMIT =
		(bpdc_pkg::FIFO_AW + 1)'(bpdc_pkg::FIFO_DEPTH - bpdc_pkg::MAX_EVENTS);

	bpdc_pkg::cfg_t                cfg_q;
	bpdc_pkg::item_t               item_s1;
	logic                          valid_s1;
	logic                          fire;
	logic                          in_beat;
	logic                          pop;
	bpdc_pkg::ev_batch_t           batch;
	logic [bpdc_pkg::FIFO_AW:0]    fifo_count;
	bpdc_pkg::fifo_entry_t         head;

	// Configuration registers: write on cfg_we, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_hold   <= POWER_HOLD_RST;
			cfg_q.reset_hold   <= RESET_HOLD_RST;
			cfg_q.import_hold  <= IMPORT_HOLD_RST;
			cfg_q.short_window <= SHORT_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpdc_pkg::CFG_POWER_HOLD:   cfg_q.power_hold   <= cfg_data;
				bpdc_pkg::CFG_RESET_HOLD:   cfg_q.reset_hold   <= cfg_data;
				bpdc_pkg::CFG_IMPORT_HOLD:  cfg_q.import_hold  <= cfg_data;
				bpdc_pkg::CFG_SHORT_WINDOW: cfg_q.short_window <= cfg_data;
				default: ;
			endcase
		end
	end

	// Evaluate the held beat once the queue has room for its worst case.
	assign fire     = valid_s1 && (fifo_count <= ROOM_LIMIT);
	// Take a new beat whenever stage 1 is empty or drains this cycle.
	assign in_ready = !valid_s1 || fire;
	assign in_beat  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of stage 1: hold until replaced by the next accepted beat.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1 <= '{op: operation, button: button, level: raw_level};
		end
	end

	bpdc_classify #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_classify (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.cfg   (cfg_q),
		.batch (batch)
	);

	// Drain the queue one event per output beat.
	assign out_valid  = (fifo_count != '0);
	assign pop        = out_valid && out_ready;
	assign event_code = head.code;
	assign last_event = head.last;

	bpdc_event_fifo u_event_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.batch (batch),
		.pop   (pop),
		.count (fifo_count),
		.head  (head)
	);

endmodule

`default_nettype wire

// File: bench/button_press_duration_classifier_unit_tb.sv
`timescale 1ns / 1ps

import bpdc_pkg::*;

localparam int COUNT_W = 20;
localparam int TICKS_PER_SEC = 100;
localparam logic [REG_W-1:0] REG_MAX = '1;
localparam logic LVL_RELEASED = 1'b1;

// Tracks the elapsed counters, armed timers and registers of the classifier
// and keeps the events it is owed, oldest first.
class button_event_scoreboard;
	logic [REG_W-1:0] hold_ticks[NUM_BTN];
	logic [REG_W-1:0] short_window;
	logic [COUNT_W-1:0] elapsed[NUM_BTN];
	bit armed[NUM_BTN];
	fifo_entry_t owed_events[$];

	function new();
		hold_ticks[BTN_POWER] = REG_W'(3 * TICKS_PER_SEC);
		hold_ticks[BTN_RESET] = REG_W'(10 * TICKS_PER_SEC);
		hold_ticks[BTN_WPS] = '0;
		hold_ticks[BTN_IMPORT] = REG_W'(3 * TICKS_PER_SEC);
		short_window = REG_W'(2 * TICKS_PER_SEC);
		for (int i = 0; i < NUM_BTN; i++) begin
			elapsed[i] = '0;
			armed[i] = 1'b0;
		end
	endfunction

	function void write_reg(logic [1:0] idx, logic [REG_W-1:0] value);
		case (idx)
			CFG_POWER_HOLD: hold_ticks[BTN_POWER] = value;
			CFG_RESET_HOLD: hold_ticks[BTN_RESET] = value;
			CFG_IMPORT_HOLD: hold_ticks[BTN_IMPORT] = value;
			CFG_SHORT_WINDOW: short_window = value;
			default: ;
		endcase
	endfunction

	// Work out the events one accepted input beat causes.
	function void note_beat(logic op, button_t b, logic lvl);
		event_t caused[$];
		fifo_entry_t ent;
		if (op == OP_TICK) begin
			for (int i = 0; i < NUM_BTN; i++)
				if (elapsed[i] != '1) elapsed[i]++;
			for (int i = 0; i < NUM_BTN; i++) begin
				if (i == BTN_WPS || !armed[i]) continue;
				if (elapsed[i] >= hold_ticks[i]) begin
					armed[i] = 1'b0;
					caused.push_back((i == BTN_POWER) ? EV_POWER_LONG :
						(i == BTN_RESET) ? EV_INIT : EV_UNMOUNT);
				end
			end
		end else if (lvl == LVL_PRESSED) begin
			elapsed[b] = '0;
			if (b == BTN_WPS) caused.push_back(EV_WPS_DOWN);
			else armed[b] = 1'b1;
		end else begin
			if (b == BTN_WPS) begin
				caused.push_back(EV_WPS_UP);
			end else begin
				armed[b] = 1'b0;
				if (b != BTN_POWER && elapsed[b] <= short_window)
					caused.push_back(b == BTN_RESET ? EV_RESET_SHORT : EV_IMPORT_SHORT);
			end
		end
		foreach (caused[k]) begin
			ent.code = caused[k];
			ent.last = (k == caused.size() - 1);
			owed_events.push_back(ent);
		end
	endfunction

	// Compare one event beat with the oldest owed event; empty string if it matches.
	function string check_beat(event_t code, logic last);
		fifo_entry_t want;
		string msg;
		if (owed_events.size() == 0)
			return $sformatf(" event_code %0d last_event %0d with nothing owed", code, last);
		want = owed_events.pop_front();
		msg = "";
		if (code !== want.code)
			msg = {msg, $sformatf(" event_code got %0d want %0d", code, want.code)};
		if (last !== want.last)
			msg = {msg, $sformatf(" last_event got %0d want %0d", last, want.last)};
		return msg;
	endfunction
endclass

module button_press_duration_classifier_unit_tb;

	localparam int QUIET_LIMIT = 2000;     // cycles with no beat on either side
	localparam int PRESSURE_CYCLES = 200;  // one long receiver hold-off

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_SAMPLE;
	button_t button = BTN_POWER;
	logic raw_level = LVL_RELEASED;
	logic out_valid;
	logic out_ready = 1'b0;
	event_t event_code;
	logic last_event;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_POWER_HOLD;
	logic [REG_W-1:0] cfg_data = '0;

	button_event_scoreboard sb;
	int error_count = 0;
	int quiet_cycles = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit stall_request = 1'b0;
	string beat_msg;

	button_press_duration_classifier_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.button(button),
		.raw_level(raw_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_code(event_code),
		.last_event(last_event),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Register value: the low end, the top end, or something small in between.
	function automatic logic [REG_W-1:0] pick_reg(int low_end);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return REG_W'(low_end);
		if (r == 1) return REG_MAX;
		return REG_W'($urandom_range(low_end, 10));
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		$display("[%0t] mismatch:%s", $time, what);
	endtask

	// Offer one input beat after an optional gap and hold it until it is taken.
	task automatic send_beat(logic op, button_t b, logic lvl);
		int gap;
		gap = send_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		button <= b;
		raw_level <= lvl;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(op, b, lvl);
	endtask

	// A tick with junk in the button and level fields; the block must ignore them.
	task automatic send_tick();
		send_beat(OP_TICK, button_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endtask

	// Drop valid, drain every owed event, then give the pipeline time to empty
	// of beats that cause nothing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.owed_events.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Mostly press / some ticks / release runs on one button, plus loose beats.
	task automatic issue_random_beats(int target);
		int sent;
		int k;
		button_t b;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 6) begin
				b = button_t'($urandom_range(0, 3));
				k = $urandom_range(0, 14);
				send_beat(OP_SAMPLE, b, LVL_PRESSED);
				repeat (k) send_tick();
				send_beat(OP_SAMPLE, b, LVL_RELEASED);
				sent += k + 2;
			end else begin
				send_beat(1'($urandom_range(0, 1)), button_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// Receiver: ready in random stretches, stalls of random length, and one
	// long hold-off on request so the event queue fills and in_ready drops.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				out_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Check every event beat the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beat_msg = sb.check_beat(event_code, last_event);
			if (beat_msg != "") report_mismatch(beat_msg);
		end
	end

	// Give up when neither channel has moved a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: short presses, release without press, wps, ignored tick fields.
		send_beat(OP_SAMPLE, BTN_RESET, LVL_PRESSED);
		send_beat(OP_SAMPLE, BTN_RESET, LVL_RELEASED);
		send_beat(OP_SAMPLE, BTN_IMPORT, LVL_RELEASED);
		send_beat(OP_SAMPLE, BTN_POWER, LVL_RELEASED);
		send_beat(OP_SAMPLE, BTN_WPS, LVL_PRESSED);
		send_beat(OP_SAMPLE, BTN_WPS, LVL_RELEASED);
		send_beat(OP_TICK, BTN_IMPORT, LVL_PRESSED);
		settle();

		// Smallest holds, empty window: all three long events on one tick, in order.
		write_reg(CFG_POWER_HOLD, REG_W'(1));
		write_reg(CFG_RESET_HOLD, REG_W'(1));
		write_reg(CFG_IMPORT_HOLD, REG_W'(1));
		write_reg(CFG_SHORT_WINDOW, '0);
		send_beat(OP_SAMPLE, BTN_POWER, LVL_PRESSED);
		send_beat(OP_SAMPLE, BTN_RESET, LVL_PRESSED);
		send_beat(OP_SAMPLE, BTN_IMPORT, LVL_PRESSED);
		send_beat(OP_TICK, BTN_WPS, LVL_RELEASED);
		send_beat(OP_SAMPLE, BTN_RESET, LVL_RELEASED);
		send_beat(OP_SAMPLE, BTN_IMPORT, LVL_RELEASED);
		settle();

		// Re-press restarts the reset timer; widest window gives a short event
		// after the long one. Import stays armed with the largest hold.
		write_reg(CFG_POWER_HOLD, REG_W'(3));
		write_reg(CFG_RESET_HOLD, REG_W'(3));
		write_reg(CFG_IMPORT_HOLD, REG_MAX);
		write_reg(CFG_SHORT_WINDOW, REG_MAX);
		send_beat(OP_SAMPLE, BTN_IMPORT, LVL_PRESSED);
		send_beat(OP_SAMPLE, BTN_RESET, LVL_PRESSED);
		send_tick();
		send_beat(OP_SAMPLE, BTN_RESET, LVL_PRESSED);
		send_tick();
		send_tick();
		send_tick();
		send_beat(OP_SAMPLE, BTN_RESET, LVL_RELEASED);
		settle();

		// Lower the import hold below its running count: fires on the next tick.
		write_reg(CFG_IMPORT_HOLD, REG_W'(2));
		send_tick();
		send_beat(OP_SAMPLE, BTN_IMPORT, LVL_RELEASED);
		settle();

		// Random segments, each under its own register setting and idling mix.
		for (int seg = 0; seg < 8; seg++) begin
			write_reg(CFG_POWER_HOLD, pick_reg(1));
			write_reg(CFG_RESET_HOLD, pick_reg(1));
			write_reg(CFG_IMPORT_HOLD, pick_reg(1));
			write_reg(CFG_SHORT_WINDOW, pick_reg(0));
			send_idle_on = (seg % 3 != 1);
			recv_idle_on = (seg % 3 != 2);
			if (seg == 0) begin
				// Keep offering beats while the receiver holds off.
				send_idle_on = 1'b0;
				stall_request = 1'b1;
			end
			issue_random_beats(36);
			settle();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
